// ===== sv/rau_pkg.sv =====
package rau_pkg;

	typedef enum logic [2:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_MUL = 3'd2,
		KIND_DIV = 3'd3,
		KIND_CMP = 3'd4
	} kind_t;

	// control bits that travel with every transaction
	typedef struct packed {
		logic valid;
		logic neg;
		logic lt;
		logic eq;
		logic gt;
	} ctrl_t;

endpackage

// ===== sv/rau_gcd_step.sv =====
module rau_gcd_step #(
	parameter int MW = 31,
	parameter int DW = 30,
	parameter int KW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  rau_pkg::ctrl_t    ctrl_i,
	input  logic [MW-1:0]     u_i,
	input  logic [DW-1:0]     v_i,
	input  logic [MW-1:0]     mag_i,
	input  logic [DW-1:0]     den_i,
	input  logic [KW-1:0]     k_i,
	output rau_pkg::ctrl_t    ctrl_o,
	output logic [MW-1:0]     u_o,
	output logic [DW-1:0]     v_o,
	output logic [MW-1:0]     mag_o,
	output logic [DW-1:0]     den_o,
	output logic [KW-1:0]     k_o
);

	logic [MW-1:0] u_d;
	logic [DW-1:0] v_d;
	logic [MW-1:0] v_ext;
	logic [MW-1:0] diff_uv;
	logic [DW-1:0] diff_vu;

	assign v_ext   = MW'(v_i);
	assign diff_uv = u_i - v_ext;
	assign diff_vu = v_i - DW'(u_i);

	// one binary gcd step, u reaching zero means done
	always_comb begin
		u_d = u_i;
		v_d = v_i;
		priority if (u_i == '0) begin
			u_d = u_i;
		end else if (!u_i[0]) begin
			u_d = u_i >> 1;
		end else if (!v_i[0]) begin
			v_d = v_i >> 1;
		end else if (u_i >= v_ext) begin
			u_d = diff_uv >> 1;
		end else begin
			v_d = diff_vu >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_o <= '0;
		end else if (en) begin
			ctrl_o <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_o   <= u_d;
			v_o   <= v_d;
			mag_o <= mag_i;
			den_o <= den_i;
			k_o   <= k_i;
		end
	end

endmodule

// ===== sv/rau_div_step.sv =====
module rau_div_step #(
	parameter int MW = 31,
	parameter int DW = 30
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  rau_pkg::ctrl_t    ctrl_i,
	input  logic [DW-1:0]     g_i,
	input  logic [DW-1:0]     rem_n_i,
	input  logic [MW-1:0]     quo_n_i,
	input  logic [DW-1:0]     rem_d_i,
	input  logic [MW-1:0]     quo_d_i,
	output rau_pkg::ctrl_t    ctrl_o,
	output logic [DW-1:0]     g_o,
	output logic [DW-1:0]     rem_n_o,
	output logic [MW-1:0]     quo_n_o,
	output logic [DW-1:0]     rem_d_o,
	output logic [MW-1:0]     quo_d_o
);

	logic [DW:0] t_n;
	logic [DW:0] t_d;
	logic [DW:0] g_ext;
	logic        b_n;
	logic        b_d;

	assign g_ext = {1'b0, g_i};
	assign t_n   = {rem_n_i, quo_n_i[MW-1]};
	assign t_d   = {rem_d_i, quo_d_i[MW-1]};
	assign b_n   = (t_n >= g_ext);
	assign b_d   = (t_d >= g_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_o <= '0;
		end else if (en) begin
			ctrl_o <= ctrl_i;
		end
	end

	// restoring division, one quotient bit per lane
	always_ff @(posedge clk) begin
		if (en) begin
			g_o     <= g_i;
			rem_n_o <= b_n ? DW'(t_n - g_ext) : DW'(t_n);
			rem_d_o <= b_d ? DW'(t_d - g_ext) : DW'(t_d);
			quo_n_o <= {quo_n_i[MW-2:0], b_n};
			quo_d_o <= {quo_d_i[MW-2:0], b_d};
		end
	end

endmodule

// ===== sv/rational_arithmetic_unit.sv =====
// channel | signals                                          | direction
// input   | in_valid in_ready kind a_num a_den b_num b_den   | in
// output  | out_valid out_ready res_num res_den is_less      | out
//         | is_equal is_greater                              |
//
// latency is set mostly by the gcd step chain and the divider chain
// one transaction enters per cycle while the output is not stalled, all stages advance together
// a stalled output freezes the whole pipeline, nothing lost or repeated
// arst_n clears only the valid and flag bits of every stage
module rational_arithmetic_unit #(
	parameter int OPERAND_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     kind,
	input  logic signed [OPERAND_BITS-1:0] a_num,
	input  logic [OPERAND_BITS-2:0]        a_den,
	input  logic signed [OPERAND_BITS-1:0] b_num,
	input  logic [OPERAND_BITS-2:0]        b_den,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [2*OPERAND_BITS:0] res_num,
	output logic [2*OPERAND_BITS-2:0]      res_den,
	output logic                           is_less,
	output logic                           is_equal,
	output logic                           is_greater
);

	localparam int P   = OPERAND_BITS;
	localparam int PW  = 2 * P;         // raw product width
	localparam int SW  = 2 * P + 1;     // sum width
	localparam int MW  = 2 * P - 1;     // numerator magnitude width
	localparam int DW  = 2 * P - 2;     // denominator width
	localparam int NW  = 2 * P + 1;     // result numerator width
	localparam int KW  = $clog2(DW);
	localparam int NG  = MW + DW;       // gcd steps

	logic en;

	// stage 1: products
	rau_pkg::ctrl_t          ctrl_s1;
	logic [2:0]              kind_s1;
	logic signed [PW-1:0]    an_bd_s1;
	logic signed [PW-1:0]    ad_bn_s1;
	logic signed [PW-1:0]    an_bn_s1;
	logic [DW-1:0]           ad_bd_s1;

	// stage 2: signed combine and magnitudes
	rau_pkg::ctrl_t          ctrl_s2;
	logic [MW-1:0]           mag_s2;
	logic [DW-1:0]           den_s2;

	// stage 3: common power of two removed
	rau_pkg::ctrl_t          ctrl_s3;
	logic [MW-1:0]           u_s3;
	logic [DW-1:0]           v_s3;
	logic [MW-1:0]           mag_s3;
	logic [DW-1:0]           den_s3;
	logic [KW-1:0]           k_s3;

	// stage 4: gcd result
	rau_pkg::ctrl_t          ctrl_s4;
	logic [DW-1:0]           g_s4;
	logic [MW-1:0]           mag_s4;
	logic [DW-1:0]           den_s4;

	// stage 5: output register
	rau_pkg::ctrl_t          ctrl_s5;
	logic signed [NW-1:0]    num_s5;
	logic [MW-1:0]           den_s5;

	assign en       = !ctrl_s5.valid || out_ready;
	assign in_ready = en;

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1 <= '{valid: in_valid, default: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1  <= kind;
			an_bd_s1 <= PW'(a_num) * PW'($signed({1'b0, b_den}));
			ad_bn_s1 <= PW'($signed({1'b0, a_den})) * PW'(b_num);
			an_bn_s1 <= PW'(a_num) * PW'(b_num);
			ad_bd_s1 <= DW'(a_den) * DW'(b_den);
		end
	end

	// stage 2: pick formula, fold signs, zero denominator gives 0/1
	logic signed [SW-1:0] num_c;
	logic signed [SW-1:0] den_c;
	logic                 arith_c;
	logic                 lt_c;
	logic                 eq_c;
	logic                 gt_c;
	logic signed [SW-1:0] num_f;
	logic signed [SW-1:0] den_f;
	logic [SW-1:0]        num_abs;
	logic [SW-1:0]        den_abs;

	always_comb begin
		num_c   = '0;
		den_c   = SW'(1);
		arith_c = 1'b1;
		lt_c    = 1'b0;
		eq_c    = 1'b0;
		gt_c    = 1'b0;
		unique case (kind_s1)
			rau_pkg::KIND_ADD: begin
				num_c = SW'(an_bd_s1) + SW'(ad_bn_s1);
				den_c = SW'($signed({1'b0, ad_bd_s1}));
			end
			rau_pkg::KIND_SUB: begin
				num_c = SW'(an_bd_s1) - SW'(ad_bn_s1);
				den_c = SW'($signed({1'b0, ad_bd_s1}));
			end
			rau_pkg::KIND_MUL: begin
				num_c = SW'(an_bn_s1);
				den_c = SW'($signed({1'b0, ad_bd_s1}));
			end
			rau_pkg::KIND_DIV: begin
				num_c = SW'(an_bd_s1);
				den_c = SW'(ad_bn_s1);
			end
			rau_pkg::KIND_CMP: begin
				arith_c = 1'b0;
				lt_c    = an_bd_s1 < ad_bn_s1;
				eq_c    = an_bd_s1 == ad_bn_s1;
				gt_c    = an_bd_s1 > ad_bn_s1;
			end
			default: begin
				arith_c = 1'b0;
			end
		endcase
		// compare, unused kinds and zero denominator all reduce to 0/1
		if (!arith_c || den_c == '0) begin
			num_f = '0;
			den_f = SW'(1);
		end else begin
			num_f = num_c;
			den_f = den_c;
		end
		num_abs = num_f[SW-1] ? SW'(-num_f) : SW'(num_f);
		den_abs = den_f[SW-1] ? SW'(-den_f) : SW'(den_f);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (en) begin
			ctrl_s2 <= '{valid: ctrl_s1.valid, neg: num_f[SW-1] ^ den_f[SW-1],
				lt: lt_c, eq: eq_c, gt: gt_c};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= MW'(num_abs);
			den_s2 <= DW'(den_abs);
		end
	end

	// stage 3: strip the shared trailing zeros
	logic [DW-1:0] or_c;
	logic [KW-1:0] k_c;

	assign or_c = DW'(mag_s2) | den_s2;

	always_comb begin
		k_c = '0;
		for (int i = DW - 1; i >= 0; i--) begin
			if (or_c[i]) begin
				k_c = KW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s3   <= mag_s2 >> k_c;
			v_s3   <= den_s2 >> k_c;
			mag_s3 <= mag_s2;
			den_s3 <= den_s2;
			k_s3   <= k_c;
		end
	end

	// binary gcd chain
	rau_pkg::ctrl_t ctrl_g [0:NG];
	logic [MW-1:0]  u_g    [0:NG];
	logic [DW-1:0]  v_g    [0:NG];
	logic [MW-1:0]  mag_g  [0:NG];
	logic [DW-1:0]  den_g  [0:NG];
	logic [KW-1:0]  k_g    [0:NG];

	assign ctrl_g[0] = ctrl_s3;
	assign u_g[0]    = u_s3;
	assign v_g[0]    = v_s3;
	assign mag_g[0]  = mag_s3;
	assign den_g[0]  = den_s3;
	assign k_g[0]    = k_s3;

	for (genvar gi = 0; gi < NG; gi++) begin : g_gcd
		rau_gcd_step #(
			.MW(MW),
			.DW(DW),
			.KW(KW)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctrl_i (ctrl_g[gi]),
			.u_i    (u_g[gi]),
			.v_i    (v_g[gi]),
			.mag_i  (mag_g[gi]),
			.den_i  (den_g[gi]),
			.k_i    (k_g[gi]),
			.ctrl_o (ctrl_g[gi+1]),
			.u_o    (u_g[gi+1]),
			.v_o    (v_g[gi+1]),
			.mag_o  (mag_g[gi+1]),
			.den_o  (den_g[gi+1]),
			.k_o    (k_g[gi+1])
		);
	end

	// stage 4: gcd is the surviving odd value times the shared power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s4 <= '0;
		end else if (en) begin
			ctrl_s4 <= ctrl_g[NG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s4   <= (DW'(u_g[NG]) | v_g[NG]) << k_g[NG];
			mag_s4 <= mag_g[NG];
			den_s4 <= den_g[NG];
		end
	end

	// divider chain, both parts over the gcd
	rau_pkg::ctrl_t ctrl_d  [0:MW];
	logic [DW-1:0]  g_d     [0:MW];
	logic [DW-1:0]  rem_n_d [0:MW];
	logic [MW-1:0]  quo_n_d [0:MW];
	logic [DW-1:0]  rem_d_d [0:MW];
	logic [MW-1:0]  quo_d_d [0:MW];

	assign ctrl_d[0]  = ctrl_s4;
	assign g_d[0]     = g_s4;
	assign rem_n_d[0] = '0;
	assign quo_n_d[0] = mag_s4;
	assign rem_d_d[0] = '0;
	assign quo_d_d[0] = MW'(den_s4);

	for (genvar di = 0; di < MW; di++) begin : g_div
		rau_div_step #(
			.MW(MW),
			.DW(DW)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctrl_i  (ctrl_d[di]),
			.g_i     (g_d[di]),
			.rem_n_i (rem_n_d[di]),
			.quo_n_i (quo_n_d[di]),
			.rem_d_i (rem_d_d[di]),
			.quo_d_i (quo_d_d[di]),
			.ctrl_o  (ctrl_d[di+1]),
			.g_o     (g_d[di+1]),
			.rem_n_o (rem_n_d[di+1]),
			.quo_n_o (quo_n_d[di+1]),
			.rem_d_o (rem_d_d[di+1]),
			.quo_d_o (quo_d_d[di+1])
		);
	end

	// stage 5: apply sign, hold result for the consumer
	logic signed [NW-1:0] qn_ext;

	assign qn_ext = $signed(NW'(quo_n_d[MW]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s5 <= '0;
		end else if (en) begin
			ctrl_s5 <= ctrl_d[MW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5 <= ctrl_d[MW].neg ? -qn_ext : qn_ext;
			den_s5 <= quo_d_d[MW];
		end
	end

	assign out_valid  = ctrl_s5.valid;
	assign res_num    = num_s5;
	assign res_den    = den_s5;
	assign is_less    = ctrl_s5.lt;
	assign is_equal   = ctrl_s5.eq;
	assign is_greater = ctrl_s5.gt;

endmodule
